/* src/bcos_pkg.sv */
// Shared types and codes of the bounded-confidence opinion block.
// Used by bcos_hist_mem and the top level; depends on nothing.
package bcos_pkg;

	// Function codes of an input beat.
	localparam logic [2:0] FUNC_LOAD   = 3'd0;
	localparam logic [2:0] FUNC_UPDATE = 3'd1;
	localparam logic [2:0] FUNC_SETTLE = 3'd2;
	localparam logic [2:0] FUNC_RDBIN  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_OP_RATE   = 3'd0;
	localparam logic [2:0] REG_OP_TOL    = 3'd1;
	localparam logic [2:0] REG_ART_RATE  = 3'd2;
	localparam logic [2:0] REG_ART_TOL   = 3'd3;
	localparam logic [2:0] REG_REN_RATE  = 3'd4;
	localparam logic [2:0] REG_COUPLING  = 3'd5;
	localparam logic [2:0] REG_SETTLE    = 3'd6;

	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int ACT_W = 40;
	localparam int HOPS  = 4;

	// One pending histogram change: the opinion whose bin moves, and the direction.
	typedef struct packed {
		logic [15:0] val;
		logic        inc;
	} hop_t;

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_P_RS   = 15'b000000000000010,
		ST_P_RL   = 15'b000000000000100,
		ST_P_MUL  = 15'b000000000001000,
		ST_P_EVAL = 15'b000000000010000,
		ST_P_WL   = 15'b000000000100000,
		ST_E_RE   = 15'b000000001000000,
		ST_E_MUL  = 15'b000000010000000,
		ST_E_EVAL = 15'b000000100000000,
		ST_R_RD   = 15'b000001000000000,
		ST_R_WR   = 15'b000010000000000,
		ST_H_RD   = 15'b000100000000000,
		ST_H_WR   = 15'b001000000000000,
		ST_RB     = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} state_t;

endpackage

/* src/bcos_opinion_mem.sv */
// Opinion store: synchronous memory, one write and one read port, read data registered.
// Depends on nothing; entries are undefined until written.
module bcos_opinion_mem #(
	parameter int DEPTH = 1025,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [15:0]   wd,
	input  logic          re,
	input  logic [AW-1:0] ra,
	output logic [15:0]   rdata_q
);

	logic [15:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

endmodule

/* src/bcos_hist_mem.sv */
// Histogram store: synchronous counter memory with per-bin valid bits.
// Depends on bcos_pkg; an invalid bin reads as zero, clear drops all valid bits at once.
module bcos_hist_mem #(
	parameter int BINS = 64,
	parameter int BW   = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     we,
	input  logic [BW-1:0]            wa,
	input  logic [bcos_pkg::CNT_W-1:0] wd,
	input  logic                     re,
	input  logic [BW-1:0]            ra,
	output logic [bcos_pkg::CNT_W-1:0] rdata_q
);
	import bcos_pkg::*;

	logic [CNT_W-1:0] mem [BINS];
	logic [BINS-1:0]  valid_q;

	// Valid bits: cleared by reset and by the clear command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wa] <= 1'b1;
		end
	end

	// Counter array write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Registered read; a bin not written since the last clear reads zero.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= valid_q[ra] ? mem[ra] : '0;
		end
	end

endmodule

/* src/bounded_confidence_opinion_step.sv */
// Top level of the bounded-confidence opinion block: sequencer and arithmetic.
// Depends on bcos_pkg, bcos_opinion_mem and bcos_hist_mem.
//
// Usage: one input beat on in_valid/in_ready carries a command (func) and its
// operands; each command gives exactly one result beat on out_valid/out_ready
// with the article value, the settle answer and the bin count.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
// A micro-update walks its opinion reads and writes one at a time through
// the opinion memory, which has one read and one write port, and applies
// each histogram change as a read-modify-write, with up to eight such
// changes per update.
// One command is worked on at a time. in_ready is high while the sequencer
// waits for work, also while an earlier result still sits in the output
// register. If the receiver stalls, the finished next result waits in the
// sequencer until the output register frees.
// Reset clears the configuration to its defaults, the histogram (through
// valid bits, at once), the activity sum and the article value. Opinion
// entries are undefined until loaded.
module bounded_confidence_opinion_step #(
	parameter int AGENTS    = 1024,
	parameter int HIST_BINS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [10:0] entry_index,
	input  logic [15:0] load_value,
	input  logic [10:0] speaker,
	input  logic [10:0] listener,
	input  logic [10:0] editor,
	input  logic [15:0] noise_draw,
	input  logic [10:0] replaced_agent,
	input  logic [15:0] fresh_opinion,
	input  logic [5:0]  bin_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] article_value,
	output logic        settled,
	output logic [10:0] bin_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import bcos_pkg::*;

	localparam int AW = $clog2(AGENTS + 1);
	localparam int BW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

	// Configuration registers.
	logic [16:0] op_rate_q, art_rate_q, ren_rate_q;
	logic [15:0] op_tol_q, art_tol_q, settle_thr_q;
	logic        coupling_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_rate_q    <= 17'd32768;
			op_tol_q     <= 16'd6554;
			art_rate_q   <= 17'd32768;
			art_tol_q    <= 16'd6554;
			ren_rate_q   <= 17'd0;
			coupling_q   <= 1'b1;
			settle_thr_q <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OP_RATE:  op_rate_q    <= cfg_data;
				REG_OP_TOL:   op_tol_q     <= cfg_data[15:0];
				REG_ART_RATE: art_rate_q   <= cfg_data;
				REG_ART_TOL:  art_tol_q    <= cfg_data[15:0];
				REG_REN_RATE: ren_rate_q   <= cfg_data;
				REG_COUPLING: coupling_q   <= cfg_data[0];
				REG_SETTLE:   settle_thr_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer state and latched operands.
	state_t state_q, ret_q;
	logic [10:0] spk_q, lis_q, edt_q, rep_q;
	logic [15:0] fresh_q, xs_q, xl_q, xe_q, ns_q;
	logic        ren_go_q;
	logic [15:0] article_q;
	logic [ACT_W-1:0] act_q;
	logic        res_settled_q;
	logic [CNT_W-1:0] res_count_q;
	hop_t        hop_q [HOPS];
	logic [2:0]  hcnt_q;
	logic [1:0]  hidx_q;
	logic signed [34:0] prod_s1;
	logic [32:0] gprod_s1;

	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Memory ports.
	logic          om_we, om_re;
	logic [AW-1:0] om_wa, om_ra;
	logic [15:0]   om_wd, om_rdata;
	logic          hm_we, hm_re, hm_clear;
	logic [BW-1:0] hm_wa, hm_ra;
	logic [CNT_W-1:0] hm_wd, hm_rdata;

	bcos_opinion_mem #(.DEPTH(AGENTS + 1), .AW(AW)) u_opinions (
		.clk(clk), .we(om_we), .wa(om_wa), .wd(om_wd),
		.re(om_re), .ra(om_ra), .rdata_q(om_rdata)
	);

	bcos_hist_mem #(.BINS(HIST_BINS), .BW(BW)) u_hist (
		.clk(clk), .arst_n(arst_n), .clear(hm_clear),
		.we(hm_we), .wa(hm_wa), .wd(hm_wd),
		.re(hm_re), .ra(hm_ra), .rdata_q(hm_rdata)
	);

	// Index checks.
	logic pair_ok, edit_ok, ren_ok, load_agent, bin_ok;
	assign pair_ok    = (spk_q != 11'd0) && (32'(spk_q) <= AGENTS) &&
	                    (lis_q != 11'd0) && (32'(lis_q) <= AGENTS);
	assign edit_ok    = (edt_q != 11'd0) && (32'(edt_q) <= AGENTS);
	assign ren_ok     = ren_go_q && (rep_q != 11'd0) && (32'(rep_q) <= AGENTS);
	assign load_agent = (entry_index != 11'd0) && (32'(entry_index) <= AGENTS);
	assign bin_ok     = 32'(bin_index) < HIST_BINS;

	// Move and gate taken from the registered products, floored.
	logic signed [17:0] d_c;
	logic [16:0]        ad_c, gate_c;
	logic signed [18:0] sum_a, sum_b;
	logic [15:0]        sat_a, sat_b;
	assign d_c    = prod_s1[33:16];
	assign ad_c   = d_c[17] ? 17'(-d_c) : 17'(d_c);
	assign gate_c = gprod_s1[32:16];

	// Pair: a = speaker + d, b = listener - d. Edit: a = article + d, b = editor - d.
	always_comb begin
		if (state_q == ST_E_EVAL) begin
			sum_a = $signed({3'b0, article_q}) + 19'(d_c);
			sum_b = $signed({3'b0, xe_q}) - 19'(d_c);
		end else begin
			sum_a = $signed({3'b0, xs_q}) + 19'(d_c);
			sum_b = $signed({3'b0, xl_q}) - 19'(d_c);
		end
		sat_a = sum_a[18] ? 16'd0 : (sum_a[17:16] != 2'd0) ? 16'hFFFF : sum_a[15:0];
		sat_b = sum_b[18] ? 16'd0 : (sum_b[17:16] != 2'd0) ? 16'hFFFF : sum_b[15:0];
	end

	logic pair_pass, edit_move;
	assign pair_pass = ad_c < gate_c;
	assign edit_move = ad_c > gate_c;

	// Bin of the pending histogram change.
	logic [31:0] hbin_w;
	assign hbin_w = {16'd0, hop_q[hidx_q].val} * 32'(HIST_BINS);

	// Activity plus |d|, saturating.
	logic [ACT_W:0] act_sum;
	logic [ACT_W-1:0] act_next;
	assign act_sum  = {1'b0, act_q} + (ACT_W + 1)'(ad_c);
	assign act_next = act_sum[ACT_W] ? '1 : act_sum[ACT_W-1:0];

	// Opinion memory control.
	always_comb begin
		om_we = 1'b0;
		om_wa = AW'(spk_q);
		om_wd = sat_a;
		om_re = 1'b0;
		om_ra = AW'(spk_q);
		unique case (state_q)
			ST_IDLE: begin
				om_we = accept && (func == FUNC_LOAD) && load_agent;
				om_wa = AW'(entry_index);
				om_wd = load_value;
			end
			ST_P_RS:   om_re = pair_ok;
			ST_P_RL: begin
				om_re = 1'b1;
				om_ra = AW'(lis_q);
			end
			ST_P_EVAL: om_we = pair_pass;
			ST_P_WL: begin
				om_we = 1'b1;
				om_wa = AW'(lis_q);
				om_wd = ns_q;
			end
			ST_E_RE: begin
				om_re = edit_ok;
				om_ra = AW'(edt_q);
			end
			ST_E_EVAL: begin
				om_we = !edit_move && coupling_q;
				om_wa = AW'(edt_q);
				om_wd = sat_b;
			end
			ST_R_RD: begin
				om_re = ren_ok;
				om_ra = AW'(rep_q);
			end
			ST_R_WR: begin
				om_we = 1'b1;
				om_wa = AW'(rep_q);
				om_wd = fresh_q;
			end
			default: ;
		endcase
	end

	// Histogram control: read in one cycle, saturating write in the next.
	always_comb begin
		hm_clear = accept && (func == FUNC_CLEAR);
		hm_re    = (state_q == ST_H_RD) || (accept && (func == FUNC_RDBIN) && bin_ok);
		hm_ra    = (state_q == ST_H_RD) ? hbin_w[16 +: BW] : BW'(bin_index);
		hm_we    = (state_q == ST_H_WR);
		hm_wa    = hbin_w[16 +: BW];
		if (hop_q[hidx_q].inc) begin
			hm_wd = (hm_rdata == CNT_MAX) ? hm_rdata : hm_rdata + 1'b1;
		end else begin
			hm_wd = (hm_rdata == '0) ? hm_rdata : hm_rdata - 1'b1;
		end
	end

	// Multiplier operands.
	logic signed [16:0] diff_c;
	logic [16:0]        mrate_c;
	logic [15:0]        mtol_c;
	always_comb begin
		if (state_q == ST_E_MUL) begin
			diff_c  = $signed({1'b0, om_rdata}) - $signed({1'b0, article_q});
			mrate_c = art_rate_q;
			mtol_c  = art_tol_q;
		end else begin
			diff_c  = $signed({1'b0, om_rdata}) - $signed({1'b0, xs_q});
			mrate_c = op_rate_q;
			mtol_c  = op_tol_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= 35'($signed({1'b0, mrate_c}) * diff_c);
		gprod_s1 <= 33'(mrate_c * mtol_c);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_DONE;
			article_q     <= '0;
			act_q         <= '0;
			hcnt_q        <= '0;
			hidx_q        <= '0;
			res_settled_q <= 1'b0;
			res_count_q   <= '0;
			out_valid     <= 1'b0;
			article_value <= '0;
			settled       <= 1'b0;
			bin_count     <= '0;
		end else begin
			// The output register fills from the sequencer or empties when taken.
			if (state_q == ST_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						spk_q         <= speaker;
						lis_q         <= listener;
						edt_q         <= editor;
						rep_q         <= replaced_agent;
						fresh_q       <= fresh_opinion;
						ren_go_q      <= {1'b0, noise_draw} < ren_rate_q;
						res_settled_q <= 1'b0;
						res_count_q   <= '0;
						hidx_q        <= '0;
						state_q       <= ST_DONE;
						unique case (func)
							FUNC_LOAD: begin
								if (entry_index == 11'd0) begin
									article_q <= load_value;
								end else if (load_agent) begin
									hop_q[0] <= '{val: load_value, inc: 1'b1};
									hcnt_q   <= 3'd1;
									ret_q    <= ST_DONE;
									state_q  <= ST_H_RD;
								end
							end
							FUNC_UPDATE: state_q <= ST_P_RS;
							FUNC_SETTLE: begin
								if (act_q <= ACT_W'(settle_thr_q)) begin
									res_settled_q <= 1'b1;
								end else begin
									act_q <= '0;
								end
							end
							FUNC_RDBIN: begin
								if (bin_ok) state_q <= ST_RB;
							end
							FUNC_CLEAR: act_q <= '0;
							default: ;
						endcase
					end
				end
				ST_P_RS: state_q <= pair_ok ? ST_P_RL : ST_E_RE;
				ST_P_RL: begin
					xs_q    <= om_rdata;
					state_q <= ST_P_MUL;
				end
				ST_P_MUL: begin
					xl_q    <= om_rdata;
					state_q <= ST_P_EVAL;
				end
				ST_P_EVAL: begin
					if (pair_pass) begin
						ns_q     <= sat_b;
						act_q    <= act_next;
						hop_q[0] <= '{val: xs_q, inc: 1'b0};
						hop_q[1] <= '{val: xl_q, inc: 1'b0};
						hop_q[2] <= '{val: sat_a, inc: 1'b1};
						hop_q[3] <= '{val: sat_b, inc: 1'b1};
						hcnt_q   <= 3'd4;
						hidx_q   <= '0;
						ret_q    <= ST_E_RE;
						state_q  <= ST_P_WL;
					end else begin
						state_q <= ST_E_RE;
					end
				end
				ST_P_WL: state_q <= ST_H_RD;
				ST_E_RE: state_q <= edit_ok ? ST_E_MUL : ST_R_RD;
				ST_E_MUL: begin
					xe_q    <= om_rdata;
					state_q <= ST_E_EVAL;
				end
				ST_E_EVAL: begin
					if (edit_move) begin
						article_q <= sat_a;
						act_q     <= act_next;
						state_q   <= ST_R_RD;
					end else if (coupling_q) begin
						act_q    <= act_next;
						hop_q[0] <= '{val: xe_q, inc: 1'b0};
						hop_q[1] <= '{val: sat_b, inc: 1'b1};
						hcnt_q   <= 3'd2;
						hidx_q   <= '0;
						ret_q    <= ST_R_RD;
						state_q  <= ST_H_RD;
					end else begin
						state_q <= ST_R_RD;
					end
				end
				ST_R_RD: state_q <= ren_ok ? ST_R_WR : ST_DONE;
				ST_R_WR: begin
					hop_q[0] <= '{val: om_rdata, inc: 1'b0};
					hop_q[1] <= '{val: fresh_q, inc: 1'b1};
					hcnt_q   <= 3'd2;
					hidx_q   <= '0;
					ret_q    <= ST_DONE;
					state_q  <= ST_H_RD;
				end
				ST_H_RD: state_q <= ST_H_WR;
				ST_H_WR: begin
					if (3'(hidx_q) + 3'd1 == hcnt_q) begin
						state_q <= ret_q;
					end else begin
						hidx_q  <= hidx_q + 2'd1;
						state_q <= ST_H_RD;
					end
				end
				ST_RB: begin
					res_count_q <= hm_rdata;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					// Hand the result to the output register once it is free.
					if (!out_valid || out_ready) begin
						article_value <= article_q;
						settled       <= res_settled_q;
						bin_count     <= res_count_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The histogram is never read and written in the same cycle.
	a_hist_rw: assert property (@(posedge clk) disable iff (!arst_n)
		hm_we |-> !hm_re) else $error("histogram read during write");

	// The opinion memory never reads an entry that is written in the same cycle.
	a_op_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(om_we && om_re) |-> (om_wa != om_ra)) else $error("opinion read/write clash");

	// The pending change list never holds more than four entries.
	a_hcnt: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= 3'(HOPS)) else $error("histogram change list overflow");

	// An accepted beat closes the input until its result is handed on.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready) else $error("input reopened while busy");

endmodule
